@@ sv/vrd_pkg.sv @@
// Package for the varint/RLE stream decoder: parse phases, the token type that
// travels from the front parser to the back accumulator, and field constants.
// Depends on nothing; every other file of the block but vrd_in_if uses it.
`timescale 1ns / 1ps
`default_nettype none

package vrd_pkg;

    localparam int VALUE_W  = 15;
    localparam int REP_W    = 14;
    localparam int BYTES_W  = 16;
    localparam int EXPECT_W = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [7:0] RUN_MARK    = 8'hFF;
    localparam logic [7:0] MAG_HI_MASK = 8'h3F;
    localparam int         LEAD_POS    = 7;
    localparam int         SIGN_POS    = 6;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_PLAIN_LO = 6'b000010,
        PH_CNT_LEAD = 6'b000100,
        PH_CNT_LO   = 6'b001000,
        PH_VAL_LEAD = 6'b010000,
        PH_VAL_LO   = 6'b100000
    } phase_t;

    // One token per accepted byte. Bytes that finish nothing still reach the back
    // part as a token, which counts the byte, and carry their end-of-buffer mark.
    typedef struct packed {
        logic                      have;
        logic                      last;
        logic signed [VALUE_W-1:0] value;
        logic [REP_W-1:0]          rep;
    } token_t;

    function automatic logic signed [VALUE_W-1:0] decode_pair(
        input logic [7:0] lead,
        input logic [7:0] low
    );
        logic signed [VALUE_W-1:0] mag;
        mag = $signed({1'b0, lead[5:0] & MAG_HI_MASK[5:0], low});
        return lead[SIGN_POS] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

@@ sv/vrd_in_if.sv @@
// Input channel of the decoder: one message byte per item.
// Depends on nothing; it uses plain widths only.
`timescale 1ns / 1ps
`default_nettype none

interface vrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

@@ sv/vrd_out_if.sv @@
// Result channel of the decoder: one (value, repeat) pair or error per item.
// Depends on vrd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vrd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vrd_pkg::VALUE_W-1:0] value;
    logic [vrd_pkg::REP_W-1:0]          repeat_count;
    logic                               message_done;
    logic                               truncated_error;
    logic [vrd_pkg::BYTES_W-1:0]        bytes_consumed;

    modport source (output valid, output value, output repeat_count, output message_done,
                    output truncated_error, output bytes_consumed, input ready);
    modport sink   (input valid, input value, input repeat_count, input message_done,
                    input truncated_error, input bytes_consumed, output ready);
endinterface

`default_nettype wire

@@ sv/vrd_front.sv @@
// Front parser: accepts bytes, tracks the varint/run phase and pushes one
// token per byte into the queue. Depends on vrd_pkg and vrd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module vrd_front (
    input  wire logic      clk,
    input  wire logic      rst_n,
    vrd_in_if.sink         byte_in,
    input  wire logic      q_full,
    output vrd_pkg::token_t tok,
    output logic           push
);

    vrd_pkg::phase_t                   phase_reg, phase_next;
    logic [7:0]                        lead_reg, lead_next;
    logic signed [vrd_pkg::VALUE_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                        b;
    logic                              cnt_pos;

    assign byte_in.ready = !q_full;
    assign push          = byte_in.valid && !q_full;
    assign b             = byte_in.data_byte;
    assign cnt_pos       = (cnt_reg > 0);

    always_comb
    begin
        phase_next = phase_reg;
        lead_next  = lead_reg;
        cnt_next   = cnt_reg;
        tok        = '0;
        tok.last   = byte_in.end_of_buffer;
        unique case (phase_reg)
            vrd_pkg::PH_PLAIN_LO:
            begin
                tok.have   = 1'b1;
                tok.value  = vrd_pkg::decode_pair(lead_reg, b);
                tok.rep    = vrd_pkg::REP_W'(1);
                phase_next = vrd_pkg::PH_IDLE;
            end
            vrd_pkg::PH_CNT_LEAD:
            begin
                if (b[vrd_pkg::LEAD_POS])
                begin
                    lead_next  = b;
                    phase_next = vrd_pkg::PH_CNT_LO;
                end
                else
                begin
                    cnt_next   = $signed({7'd0, b});
                    phase_next = vrd_pkg::PH_VAL_LEAD;
                end
            end
            vrd_pkg::PH_CNT_LO:
            begin
                cnt_next   = vrd_pkg::decode_pair(lead_reg, b);
                phase_next = vrd_pkg::PH_VAL_LEAD;
            end
            vrd_pkg::PH_VAL_LEAD:
            begin
                if (b[vrd_pkg::LEAD_POS])
                begin
                    lead_next  = b;
                    phase_next = vrd_pkg::PH_VAL_LO;
                end
                else
                begin
                    tok.have   = cnt_pos;
                    tok.value  = $signed({7'd0, b});
                    tok.rep    = cnt_reg[vrd_pkg::REP_W-1:0];
                    phase_next = vrd_pkg::PH_IDLE;
                end
            end
            vrd_pkg::PH_VAL_LO:
            begin
                tok.have   = cnt_pos;
                tok.value  = vrd_pkg::decode_pair(lead_reg, b);
                tok.rep    = cnt_reg[vrd_pkg::REP_W-1:0];
                phase_next = vrd_pkg::PH_IDLE;
            end
            default:
            begin
                if (b == vrd_pkg::RUN_MARK)
                begin
                    phase_next = vrd_pkg::PH_CNT_LEAD;
                end
                else if (b[vrd_pkg::LEAD_POS])
                begin
                    lead_next  = b;
                    phase_next = vrd_pkg::PH_PLAIN_LO;
                end
                else
                begin
                    tok.have   = 1'b1;
                    tok.value  = $signed({7'd0, b});
                    tok.rep    = vrd_pkg::REP_W'(1);
                    phase_next = vrd_pkg::PH_IDLE;
                end
            end
        endcase
        // The last byte always ends the message, either done or truncated,
        // so the parser restarts whatever the back part decides.
        if (byte_in.end_of_buffer)
        begin
            phase_next = vrd_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vrd_pkg::PH_IDLE;
            lead_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            lead_reg  <= lead_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/vrd_queue.sv @@
// Short token queue between the front parser and the back accumulator.
// Depends on vrd_pkg for the token type and depth.
`timescale 1ns / 1ps
`default_nettype none

module vrd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire vrd_pkg::token_t  push_tok,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output vrd_pkg::token_t       pop_tok
);

    vrd_pkg::token_t                 entry_reg [vrd_pkg::QDEPTH];
    logic [vrd_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [vrd_pkg::QPTR_W:0]        cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign full    = (cnt_reg == (vrd_pkg::QPTR_W + 1)'(vrd_pkg::QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign pop_tok = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

@@ sv/vrd_back.sv @@
// Back accumulator: counts bytes and values per message, decides done or
// truncation and holds the result register. Depends on vrd_pkg and vrd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module vrd_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [vrd_pkg::EXPECT_W-1:0]    values_expected,
    input  wire logic                            q_valid,
    input  wire vrd_pkg::token_t                 tok,
    output logic                                 pop,
    vrd_out_if.source                            result_out
);

    localparam int SUMW = ((COUNT_WIDTH > vrd_pkg::REP_W) ? COUNT_WIDTH : vrd_pkg::REP_W) + 1;
    localparam int CMPW = (COUNT_WIDTH > vrd_pkg::EXPECT_W) ? COUNT_WIDTH : vrd_pkg::EXPECT_W;
    localparam int SHW  = (COUNT_WIDTH > vrd_pkg::BYTES_W) ? COUNT_WIDTH : vrd_pkg::BYTES_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]             bc_reg, bc_next, bc_inc;
    logic [COUNT_WIDTH-1:0]             vc_reg, vc_next, vc_new;
    logic [SUMW-1:0]                    vc_sum;
    logic [SHW-1:0]                     bc_wide;
    logic [vrd_pkg::BYTES_W-1:0]        shown;
    logic [vrd_pkg::EXPECT_W-1:0]       need;
    logic                               done, restart, emit;

    logic                               out_valid_reg;
    logic signed [vrd_pkg::VALUE_W-1:0] value_reg;
    logic [vrd_pkg::REP_W-1:0]          rep_reg;
    logic                               done_reg, err_reg;
    logic [vrd_pkg::BYTES_W-1:0]        bytes_reg;

    assign pop = q_valid && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        bc_inc  = (bc_reg == CNT_MAX) ? bc_reg : bc_reg + 1'b1;
        vc_sum  = SUMW'(vc_reg) + SUMW'(tok.rep);
        vc_new  = (vc_sum > SUMW'(CNT_MAX)) ? CNT_MAX : vc_sum[COUNT_WIDTH-1:0];
        need    = (values_expected == '0) ? vrd_pkg::EXPECT_W'(1) : values_expected;
        done    = tok.have && (CMPW'(vc_new) >= CMPW'(need));
        restart = done || tok.last;
        emit    = tok.have || tok.last;
        bc_wide = SHW'(bc_inc);
        shown   = (bc_wide > SHW'({vrd_pkg::BYTES_W{1'b1}})) ? {vrd_pkg::BYTES_W{1'b1}}
                                                            : bc_wide[vrd_pkg::BYTES_W-1:0];
        bc_next = restart ? '0 : bc_inc;
        vc_next = restart ? '0 : (tok.have ? vc_new : vc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg        <= '0;
            vc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                bc_reg        <= bc_next;
                vc_reg        <= vc_next;
                out_valid_reg <= emit;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            bytes_reg <= shown;
            // A byte that ends the buffer short of done drops any value it finished.
            if (tok.last && !done)
            begin
                value_reg <= '0;
                rep_reg   <= '0;
                done_reg  <= 1'b0;
                err_reg   <= 1'b1;
            end
            else
            begin
                value_reg <= tok.value;
                rep_reg   <= tok.rep;
                done_reg  <= done;
                err_reg   <= 1'b0;
            end
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.value           = value_reg;
    assign result_out.repeat_count    = rep_reg;
    assign result_out.message_done    = done_reg;
    assign result_out.truncated_error = err_reg;
    assign result_out.bytes_consumed  = bytes_reg;

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && restart |=> (bc_reg == '0) && (vc_reg == '0))
        else $error("counters not cleared after message end");

    a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> !done_reg && (rep_reg == '0) && (value_reg == '0))
        else $error("truncation result carries a value");

    a_bytes_grow: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !restart |=> bc_reg >= $past(bc_reg))
        else $error("byte counter went backward inside a message");

    a_result_counts_byte: assert property (@(posedge clk) disable iff (!rst_n)
        pop && emit |=> out_valid_reg && (bytes_reg != '0))
        else $error("result shows no consumed bytes");
`endif

endmodule

`default_nettype wire

@@ sv/varint_rle_stream_decoder.sv @@
// Decodes a stream of one-byte items into signed values and runs. Throughput is
// one byte per clock cycle while the result channel is ready; a result passes
// from the front parser into the token queue and then from the back
// accumulator into the result register. A stalled result
// channel fills the two-entry token queue before byte_in.ready drops. Write
// values_expected only while no message is in flight. No reset sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module varint_rle_stream_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vrd_pkg::EXPECT_W-1:0]  cfg_wdata,
    vrd_in_if.sink                             byte_in,
    vrd_out_if.source                          result_out
);

    logic [vrd_pkg::EXPECT_W-1:0] values_expected_reg;
    vrd_pkg::token_t              front_tok, q_tok;
    logic                         push, q_full, q_valid, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            values_expected_reg <= vrd_pkg::EXPECT_W'(1);
        end
        else if (cfg_we)
        begin
            values_expected_reg <= cfg_wdata;
        end
    end

    vrd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .q_full  (q_full),
        .tok     (front_tok),
        .push    (push)
    );

    vrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (front_tok),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_tok  (q_tok)
    );

    vrd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .values_expected (values_expected_reg),
        .q_valid         (q_valid),
        .tok             (q_tok),
        .pop             (pop),
        .result_out      (result_out)
    );

endmodule

`default_nettype wire
